// ----- hdl/acpt_pkg.sv -----
// shared types and constants for the box collision push table
package acpt_pkg;

   localparam int MaxBoxes = 16;
   localparam int IdxW = 4;

   localparam logic [1:0] ACT_CREATE = 2'd0;
   localparam logic [1:0] ACT_SET    = 2'd1;
   localparam logic [1:0] ACT_MOVE   = 2'd2;
   localparam logic [1:0] ACT_QUERY  = 2'd3;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [14:0]        w;
      logic [14:0]        h;
   } box_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic              wr;
      logic [1:0]        act;
      logic [IdxW-1:0]   idx;
      logic signed [15:0] xv;
      logic signed [15:0] yv;
      logic [14:0]       w;
      logic [14:0]       h;
   } cmd_type;

   // token that walks along the chain during a query
   typedef struct packed {
      logic            vld;
      logic [IdxW-1:0] qidx;
      box_type         q;
   } tok_type;

   // result of one cell compare
   typedef struct packed {
      logic            vld;
      logic            hit;
      logic [IdxW-1:0] other;
      logic [1:0]      px;
      logic [1:0]      py;
   } res_type;

   function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
      logic signed [15:0] r;
      if (v > 17'sd32767) r = 16'sh7fff;
      else if (v < -17'sd32768) r = 16'sh8000;
      else r = v[15:0];
      return r;
   endfunction

endpackage

// ----- hdl/acpt_cell.sv -----
// one table slot: holds a box, applies updates and compares a passing query token
module acpt_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [acpt_pkg::IdxW-1:0]           my_idx,
   input  acpt_pkg::cmd_type                   cmd,
   input  logic                                adv,
   input  acpt_pkg::tok_type                   tok_i,
   output acpt_pkg::tok_type                   tok_o,
   output acpt_pkg::res_type                   res_o,
   output acpt_pkg::box_type                   box_o,
   output logic                                valid_o
);
   acpt_pkg::box_type box_ff, box_in;
   logic signed [15:0] offx_ff, offx_in, offy_ff, offy_in;
   logic valid_ff, valid_in;
   acpt_pkg::tok_type tok_ff;
   acpt_pkg::res_type res_ff, res_in;
   logic sel;
   logic signed [16:0] qx1, qy1, ox1, oy1, ix0, ix1, iy0, iy1;
   logic signed [17:0] iw, ih;
   logic ovl;

   assign sel = cmd.wr && (cmd.idx == my_idx);

   always_comb begin
      box_in = box_ff; offx_in = offx_ff; offy_in = offy_ff; valid_in = valid_ff;
      if (sel) begin
         case (cmd.act)
            acpt_pkg::ACT_CREATE: begin
               box_in.x = cmd.xv; box_in.y = cmd.yv; box_in.w = cmd.w; box_in.h = cmd.h;
               offx_in = cmd.xv; offy_in = cmd.yv; valid_in = 1'b1;
            end
            acpt_pkg::ACT_SET: if (valid_ff) begin
               box_in.x = acpt_pkg::sat16(17'(cmd.xv) + 17'(offx_ff));
               box_in.y = acpt_pkg::sat16(17'(cmd.yv) + 17'(offy_ff));
            end
            acpt_pkg::ACT_MOVE: if (valid_ff) begin
               box_in.x = acpt_pkg::sat16(17'(box_ff.x) + 17'(cmd.xv));
               box_in.y = acpt_pkg::sat16(17'(box_ff.y) + 17'(cmd.yv));
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      qx1 = 17'(tok_i.q.x) + 17'(signed'({1'b0, tok_i.q.w}));
      qy1 = 17'(tok_i.q.y) + 17'(signed'({1'b0, tok_i.q.h}));
      ox1 = 17'(box_ff.x) + 17'(signed'({1'b0, box_ff.w}));
      oy1 = 17'(box_ff.y) + 17'(signed'({1'b0, box_ff.h}));
      ix0 = (box_ff.x > tok_i.q.x) ? 17'(box_ff.x) : 17'(tok_i.q.x);
      iy0 = (box_ff.y > tok_i.q.y) ? 17'(box_ff.y) : 17'(tok_i.q.y);
      ix1 = (ox1 < qx1) ? ox1 : qx1;
      iy1 = (oy1 < qy1) ? oy1 : qy1;
      iw = 18'(ix1) - 18'(ix0);
      ih = 18'(iy1) - 18'(iy0);
      ovl = valid_ff && (tok_i.qidx != my_idx) && (box_ff.w != '0) && (box_ff.h != '0)
            && (tok_i.q.w != '0) && (tok_i.q.h != '0) && (iw >= 18'sd1) && (ih >= 18'sd1);
      res_in.vld = tok_i.vld && ovl;
      res_in.hit = 1'b1;
      res_in.other = my_idx;
      if (iw > ih) begin
         res_in.px = 2'b00;
         res_in.py = (tok_i.q.y > box_ff.y) ? 2'b01 : 2'b11;
      end else begin
         res_in.px = (tok_i.q.x > box_ff.x) ? 2'b01 : 2'b11;
         res_in.py = 2'b00;
      end
   end

   // token and compare result move only when the chain advances
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         box_ff <= '0;
         offx_ff <= '0;
         offy_ff <= '0;
         tok_ff <= '0;
         res_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         box_ff <= box_in;
         offx_ff <= offx_in;
         offy_ff <= offy_in;
         if (adv) begin
            tok_ff <= tok_i;
            res_ff <= res_in;
         end
      end
   end

   assign tok_o = tok_ff;
   assign res_o = res_ff;
   assign box_o = box_ff;
   assign valid_o = valid_ff;
endmodule

// ----- hdl/aabb_collision_push_table_core.sv -----
// top level: controller, chain of slot cells and result register
// create, set and move are taken in idle and may follow back to back
// query: token walks the MaxBoxes cells one per cycle unless a result stalls; the last
// result carries rsp_tlast, then idle again; an empty slot skips the walk, no hit
// reset: synchronous, active high, clears every slot; an untaken result freezes the walk
module aabb_collision_push_table_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // action[1:0], box_index[5:2], x_val[21:6], y_val[37:22], width[52:38], height[67:53]
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // other_box[3:0], push_x[5:4], push_y[7:6]
   output logic [7:0]  rsp_tdata,
   // hit
   output logic        rsp_tuser,
   output logic        rsp_tlast
);
   localparam int N = acpt_pkg::MaxBoxes;
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_LAST = 2'd2;

   logic [1:0] state_ff, state_in;
   acpt_pkg::cmd_type cmd;
   acpt_pkg::tok_type tok_ch [N+1];
   acpt_pkg::tok_type tok0_ff, tok0_in;
   acpt_pkg::res_type res_c [N];
   acpt_pkg::box_type box_c [N];
   acpt_pkg::res_type stash_ff, stash_in;
   acpt_pkg::res_type cur;
   logic [N-1:0] vld_c;
   logic hold_ff, hold_in;
   logic [acpt_pkg::IdxW-1:0] ob_ff, ob_in;
   logic [1:0] px_ff, px_in, py_ff, py_in;
   logic hit_ff, hit_in, lst_ff, lst_in;
   logic acc, qok, adv;
   logic [acpt_pkg::IdxW-1:0] ridx;

   assign acc = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign ridx = req_tdata[5:2];

   always_comb begin
      cmd.wr = acc;
      cmd.act = req_tdata[1:0];
      cmd.idx = ridx;
      cmd.xv = req_tdata[21:6];
      cmd.yv = req_tdata[37:22];
      cmd.w = req_tdata[52:38];
      cmd.h = req_tdata[67:53];
   end

   assign qok = vld_c[ridx];

   // chain advances only when the output register is free
   assign adv = (state_ff == ST_WALK) && (!hold_ff || rsp_tready);

   assign tok_ch[0] = tok0_ff;

   // chain of cells: a query token enters at cell 0 and moves one cell per advance
   genvar g;
   generate
      for (g = 0; g < N; g++) begin : g_cell
         acpt_cell u_cell (
            .clock(clock), .reset(reset), .my_idx(acpt_pkg::IdxW'(g)), .cmd(cmd),
            .adv(adv), .tok_i(tok_ch[g]), .tok_o(tok_ch[g+1]), .res_o(res_c[g]),
            .box_o(box_c[g]), .valid_o(vld_c[g])
         );
      end
   endgenerate

   always_comb begin
      cur = '0;
      for (int i = 0; i < N; i++) if (res_c[i].vld) cur = res_c[i];
   end

   // newest push waits in the stash until the next one shows it is not the last
   always_comb begin
      state_in = state_ff; tok0_in = tok0_ff; stash_in = stash_ff;
      hold_in = hold_ff && !rsp_tready;
      ob_in = ob_ff; px_in = px_ff; py_in = py_ff; hit_in = hit_ff; lst_in = lst_ff;
      case (state_ff)
         ST_IDLE: if (acc && cmd.act == acpt_pkg::ACT_QUERY) begin
            stash_in = '0;
            if (qok) begin
               state_in = ST_WALK;
               tok0_in.vld = 1'b1;
               tok0_in.qidx = ridx;
               tok0_in.q = box_c[ridx];
            end else begin
               state_in = ST_LAST;
            end
         end
         ST_WALK: if (adv) begin
            tok0_in.vld = 1'b0;
            if (cur.vld) begin
               if (stash_ff.vld) begin
                  hold_in = 1'b1; ob_in = stash_ff.other; px_in = stash_ff.px;
                  py_in = stash_ff.py; hit_in = 1'b1; lst_in = 1'b0;
               end
               stash_in = cur;
            end
            if (tok_ch[N].vld) state_in = ST_LAST;
         end
         ST_LAST: if (!hold_ff || rsp_tready) begin
            hold_in = 1'b1; lst_in = 1'b1;
            if (stash_ff.vld) begin
               ob_in = stash_ff.other; px_in = stash_ff.px; py_in = stash_ff.py;
               hit_in = 1'b1;
            end else begin
               ob_in = '0; px_in = '0; py_in = '0; hit_in = 1'b0;
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      ob_ff <= ob_in; px_ff <= px_in; py_ff <= py_in; hit_ff <= hit_in; lst_ff <= lst_in;
      if (reset) begin
         state_ff <= ST_IDLE; hold_ff <= 1'b0; tok0_ff <= '0; stash_ff <= '0;
      end else begin
         state_ff <= state_in; hold_ff <= hold_in; tok0_ff <= tok0_in; stash_ff <= stash_in;
      end
   end

   assign rsp_tvalid = hold_ff;
   assign rsp_tdata = {py_ff, px_ff, ob_ff};
   assign rsp_tuser = hit_ff;
   assign rsp_tlast = lst_ff;
endmodule
